// ----- hdl/dmx_pkg.sv -----
// Shared types, opcodes and phase codes for the DMX512 frame receiver.
package dmx_pkg;

  localparam int STORE_DEPTH = 512;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int PW          = AW + 1;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_LINE = 2'd1,
    OP_POLL = 2'd2,
    OP_READ = 2'd3
  } opcode_t;

  // Receiver phase, one-hot
  typedef enum logic [2:0] {
    PH_IGNORE = 3'b001,
    PH_BREAK  = 3'b010,
    PH_ACTIVE = 3'b100
  } phase_t;

  // Phase codes as reported on the result
  localparam logic [1:0] PC_IGNORE = 2'd0;
  localparam logic [1:0] PC_BREAK  = 2'd1;
  localparam logic [1:0] PC_ACTIVE = 2'd2;

  typedef struct packed {
    opcode_t        opcode;
    logic [7:0]     rx_byte;
    logic           break_seen;
    logic [AW-1:0]  read_index;
  } item_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       changed;
    logic [1:0] rx_phase;
    logic [7:0] odd_start_code;
  } result_t;

  // Front end to back end: what the second stage needs of one item
  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] rx_byte;
    logic       wrote;
    logic       old_valid;
    logic [1:0] rx_phase;
    logic [7:0] odd_code;
  } stage_t;

  // Front end status
  typedef struct packed {
    logic [PW-1:0] ptr;
    logic [PW-1:0] fill;
  } stat_t;

  function automatic logic [1:0] phase_code(phase_t p);
    logic [1:0] c;
    case (p)
      PH_BREAK:  c = PC_BREAK;
      PH_ACTIVE: c = PC_ACTIVE;
      default:   c = PC_IGNORE;
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/dmx_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dmx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wa,
  input  logic [WIDTH-1:0] wd,
  input  logic             re,
  input  logic [AW-1:0]    ra,
  output logic [WIDTH-1:0] rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on an address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

// ----- hdl/dmx_front.sv -----
// Accept-side logic: receiver phase, slot pointer, fill count and RAM addressing.
module dmx_front #(
  parameter int CHANNELS = 512
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  dmx_pkg::item_t               item,
  output dmx_pkg::stage_t              stage,
  output dmx_pkg::stat_t               stat,
  output logic                         ram_we,
  output logic [dmx_pkg::AW-1:0]       ram_wa,
  output logic [7:0]                   ram_wd,
  output logic                         ram_re,
  output logic [dmx_pkg::AW-1:0]       ram_ra
);
  import dmx_pkg::*;

  localparam logic [PW-1:0] LIMIT = PW'(CHANNELS);
  localparam logic [PW-1:0] LAST  = PW'(CHANNELS - 1);

  phase_t        phase, phase_next;
  logic [PW-1:0] ptr, ptr_next;
  logic [PW-1:0] fill, fill_next;
  logic [7:0]    odd_code, odd_code_next;
  logic          wr;
  logic          old_valid;

  // Next state for one item
  always_comb begin
    phase_next    = phase;
    ptr_next      = ptr;
    fill_next     = fill;
    odd_code_next = odd_code;
    wr            = 1'b0;
    case (item.opcode)
      OP_BYTE: begin
        case (phase)
          PH_BREAK: begin
            if (item.rx_byte != 8'd0) begin
              odd_code_next = item.rx_byte;
              phase_next    = PH_IGNORE;
            end else begin
              phase_next = PH_ACTIVE;
              ptr_next   = '0;
            end
          end
          PH_ACTIVE: begin
            if (ptr >= LIMIT) begin
              phase_next = PH_IGNORE;
            end else begin
              wr       = 1'b1;
              ptr_next = ptr + PW'(1);
              if (ptr == LAST) begin
                phase_next = PH_IGNORE;
              end
              // slots are written in order from zero, so the fill count only grows by one
              if (ptr >= fill) begin
                fill_next = ptr + PW'(1);
              end
            end
          end
          default: ;
        endcase
      end
      OP_LINE: begin
        if (item.break_seen) begin
          phase_next = PH_BREAK;
        end
      end
      default: ;
    endcase
  end

  // Slots at or past the fill count were never written and read as zero
  always_comb begin
    if (item.opcode == OP_READ) begin
      old_valid = {1'b0, item.read_index} < fill;
    end else begin
      old_valid = ptr < fill;
    end
  end

  // RAM access: write the byte and fetch the old value in the same edge
  assign ram_we = accept && wr;
  assign ram_wa = ptr[AW-1:0];
  assign ram_wd = item.rx_byte;
  assign ram_re = accept && (wr || item.opcode == OP_READ);
  assign ram_ra = (item.opcode == OP_READ) ? item.read_index : ptr[AW-1:0];

  assign stage.opcode    = item.opcode;
  assign stage.rx_byte   = item.rx_byte;
  assign stage.wrote     = wr;
  assign stage.old_valid = old_valid;
  assign stage.rx_phase  = phase_code(phase_next);
  assign stage.odd_code  = odd_code_next;

  assign stat.ptr  = ptr;
  assign stat.fill = fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IGNORE;
      ptr      <= '0;
      fill     <= '0;
      odd_code <= '0;
    end else if (accept) begin
      phase    <= phase_next;
      ptr      <= ptr_next;
      fill     <= fill_next;
      odd_code <= odd_code_next;
    end
  end

endmodule

// ----- hdl/dmx_back.sv -----
// Second stage: compare with old value, changed flag, result register.
module dmx_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  dmx_pkg::stage_t   stage,
  input  logic [7:0]        ram_rd,
  input  logic              result_ready,
  output logic              item_ready,
  output logic              s1_valid,
  output logic              result_valid,
  output dmx_pkg::result_t  result
);
  import dmx_pkg::*;

  stage_t     s1;
  logic       changed_flag, changed_flag_next;
  logic       go;
  logic [7:0] old;
  result_t    result_next;

  assign go         = !result_valid || result_ready;
  assign item_ready = !s1_valid || go;

  assign old = s1.old_valid ? ram_rd : 8'd0;

  // Changed flag and result for the item in the second stage
  always_comb begin
    changed_flag_next = changed_flag;
    if (s1.opcode == OP_POLL) begin
      changed_flag_next = 1'b0;
    end
    if (s1.wrote && (old != s1.rx_byte)) begin
      changed_flag_next = 1'b1;
    end
    result_next.read_value     = (s1.opcode == OP_READ) ? old : 8'd0;
    result_next.changed        = changed_flag;
    result_next.rx_phase       = s1.rx_phase;
    result_next.odd_start_code = s1.odd_code;
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      changed_flag <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (go) begin
        s1_valid <= 1'b0;
      end
      if (go) begin
        result_valid <= s1_valid;
      end
      if (s1_valid && go) begin
        changed_flag <= changed_flag_next;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= stage;
    end
    if (s1_valid && go) begin
      result <= result_next;
    end
  end

endmodule

// ----- hdl/dmx512_frame_receiver.sv -----
// DMX512 frame receiver top level: front end, channel store RAM, back end.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------
//   item     | item_valid / item_ready    | item   (dmx_pkg::item_t)
//   result   | result_valid / result_ready| result (dmx_pkg::result_t)
//
// Each item passes through two registers: the accept edge updates the
// receiver state and issues the channel RAM read/write, then the second
// stage compares the old value and loads the result register once the
// result register is free. One item per cycle while result_ready keeps up.
// Reset clears control state; the channel store is not swept, slots past
// the fill count read as zero. A stalled result holds one item back in
// the second stage while the input still takes a transfer if that stage is free.
module dmx512_frame_receiver #(
  parameter int CHANNELS = 512
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  dmx_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_ready,
  output dmx_pkg::result_t  result
);
  import dmx_pkg::*;

  logic          accept;
  stage_t        stage;
  stat_t         stat;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [7:0]    ram_wd, ram_rd;
  logic          s1_valid;

  assign accept = item_valid && item_ready;

  dmx_front #(.CHANNELS(CHANNELS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .stage  (stage),
    .stat   (stat),
    .ram_we (ram_we),
    .ram_wa (ram_wa),
    .ram_wd (ram_wd),
    .ram_re (ram_re),
    .ram_ra (ram_ra)
  );

  dmx_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .re  (ram_re),
    .ra  (ram_ra),
    .rd  (ram_rd)
  );

  dmx_back u_back (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .stage        (stage),
    .ram_rd       (ram_rd),
    .result_ready (result_ready),
    .item_ready   (item_ready),
    .s1_valid     (s1_valid),
    .result_valid (result_valid),
    .result       (result)
  );

  // Empty second stage never blocks a transfer
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> item_ready)
    else $error("item_ready low with empty second stage");

  // Writes run in order from slot zero, so the pointer never passes the fill count
  a_fill_covers_ptr: assert property (@(posedge clk) disable iff (rst)
    stat.ptr <= stat.fill)
    else $error("slot pointer beyond fill count");

  // A transfer always lands in the second stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted item lost before second stage");

endmodule
